[rtl/sbkc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbkc_pkg
// Shared types and constants of the sphere bounds kill-or-clamp pipeline.
// ----------------------------------------------------------------------------
package sbkc_pkg;

	// Number of root bits produced by the square root pipeline (one per stage).
	localparam int SQ_STEPS = 34;
	// Number of quotient bits produced by the divider pipeline (one per stage).
	localparam int QBITS = 31;
	// Front stages: difference, square, sum, compare.
	localparam int FRONT_STAGES = 4;
	// Cycles from an accepted item to its result strobe.
	localparam int LATENCY = FRONT_STAGES + SQ_STEPS + 1 + QBITS + 1;

	// Per-item data that rides along to the output stage.
	typedef struct packed {
		logic            last;
		logic            outside;
		logic [2:0]      neg;
		logic [2:0][31:0] pos;
	} meta_t;

	// Data handed from the front stages through the square root pipeline.
	typedef struct packed {
		meta_t            meta;
		logic [2:0][31:0] mag;
	} item_t;

endpackage

[rtl/sphere_bounds_kill_or_clamp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphere_bounds_kill_or_clamp
// Sphere bounds test for a stream of Q16.16 particle positions.
// ----------------------------------------------------------------------------
// The block takes one particle every clock cycle (busy is never raised) and
// delivers each result in order, with a one-cycle done strobe; the receiver
// cannot stall it. The pipeline has four front stages (difference, square,
// sum, compare), 34 square root stages at one root bit each, one multiply
// stage, 31 divider stages at one quotient bit each, and the output register.
// Configuration writes are always accepted and load their register in the
// next cycle; write them only while no particle is in flight.
// ----------------------------------------------------------------------------
module sphere_bounds_kill_or_clamp (
	input  logic        clk,
	input  logic        arst_n,
	// Particle input.
	input  logic        start,
	output logic        busy,
	input  logic [31:0] pos_x,
	input  logic [31:0] pos_y,
	input  logic [31:0] pos_z,
	input  logic        last_particle,
	// Configuration write channel.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	// Result output.
	output logic        done,
	output logic [31:0] out_x,
	output logic [31:0] out_y,
	output logic [31:0] out_z,
	output logic        remove,
	output logic        last_out
);
	import sbkc_pkg::*;

	localparam logic [2:0] REG_CENTER_X = 3'd0;
	localparam logic [2:0] REG_CENTER_Y = 3'd1;
	localparam logic [2:0] REG_CENTER_Z = 3'd2;
	localparam logic [2:0] REG_RADIUS   = 3'd3;
	localparam logic [2:0] REG_MODE     = 3'd4;

	// Configuration registers.
	logic [2:0][31:0] center_q;
	logic [30:0]      radius_q;
	logic             mode_q;
	logic [61:0]      r2_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q <= '0;
			radius_q <= 31'd196608;
			mode_q   <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_CENTER_X: center_q[0] <= cfg_data;
				REG_CENTER_Y: center_q[1] <= cfg_data;
				REG_CENTER_Z: center_q[2] <= cfg_data;
				REG_RADIUS:   radius_q    <= cfg_data[30:0];
				REG_MODE:     mode_q      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Radius squared is registered from the radius register in the next cycle.
	always_ff @(posedge clk) begin
		r2_q <= 62'(radius_q * radius_q);
	end

	// Stage 1: difference to the center, split into sign and magnitude.
	logic             vld_s1;
	meta_t            meta_s1;
	logic [2:0][31:0] mag_s1;
	logic [2:0][31:0] pos_in;

	assign pos_in = {pos_z, pos_y, pos_x};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		logic [32:0] d;
		meta_s1.last    <= last_particle;
		meta_s1.outside <= 1'b0;
		meta_s1.pos     <= pos_in;
		for (int k = 0; k < 3; k++) begin
			d = {pos_in[k][31], pos_in[k]} - {center_q[k][31], center_q[k]};
			meta_s1.neg[k] <= d[32];
			mag_s1[k] <= d[32] ? 32'(-d) : d[31:0];
		end
	end

	// Stage 2: squares of the magnitudes.
	logic             vld_s2;
	meta_t            meta_s2;
	logic [2:0][31:0] mag_s2;
	logic [2:0][63:0] sq_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		meta_s2 <= meta_s1;
		mag_s2  <= mag_s1;
		for (int k = 0; k < 3; k++) begin
			sq_s2[k] <= mag_s1[k] * mag_s1[k];
		end
	end

	// Stage 3: squared distance.
	logic             vld_s3;
	meta_t            meta_s3;
	logic [2:0][31:0] mag_s3;
	logic [65:0]      dsq_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		meta_s3 <= meta_s2;
		mag_s3  <= mag_s2;
		dsq_s3  <= {2'b00, sq_s2[0]} + {2'b00, sq_s2[1]} + {2'b00, sq_s2[2]};
	end

	// Stage 4: outside test against radius squared.
	logic        vld_s4;
	item_t       item_s4;
	logic [65:0] dsq_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		item_s4.meta.last    <= meta_s3.last;
		item_s4.meta.neg     <= meta_s3.neg;
		item_s4.meta.pos     <= meta_s3.pos;
		item_s4.meta.outside <= (dsq_s3 > {4'b0000, r2_q});
		item_s4.mag          <= mag_s3;
		dsq_s4               <= dsq_s3;
	end

	// Distance to the center.
	logic        sq_valid;
	item_t       sq_item;
	logic [33:0] sq_root;

	sbkc_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s4),
		.in_item   (item_s4),
		.in_rad    (dsq_s4),
		.out_valid (sq_valid),
		.out_item  (sq_item),
		.out_root  (sq_root)
	);

	// Surface offsets |diff| * radius / distance.
	logic             dv_valid;
	meta_t            dv_meta;
	logic [2:0][30:0] dv_quot;

	sbkc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sq_valid),
		.in_item   (sq_item),
		.in_dist   (sq_root),
		.radius    (radius_q),
		.out_valid (dv_valid),
		.out_meta  (dv_meta),
		.out_quot  (dv_quot)
	);

	// Output stage: apply sign, add the center, saturate and select.
	logic [2:0][31:0] res_q;
	logic             remove_q;
	logic             last_q;
	logic             done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		logic signed [32:0] off;
		logic signed [33:0] sum;
		last_q   <= dv_meta.last;
		remove_q <= dv_meta.outside && !mode_q;
		for (int k = 0; k < 3; k++) begin
			off = dv_meta.neg[k] ? -$signed({2'b00, dv_quot[k]}) : $signed({2'b00, dv_quot[k]});
			sum = 34'($signed({{2{center_q[k][31]}}, center_q[k]})) + 34'(off);
			if (!(dv_meta.outside && mode_q)) begin
				res_q[k] <= dv_meta.pos[k];
			end else if (sum > 34'sh0_7FFF_FFFF) begin
				res_q[k] <= 32'h7FFF_FFFF;
			end else if (sum < -34'sh0_8000_0000) begin
				res_q[k] <= 32'h8000_0000;
			end else begin
				res_q[k] <= sum[31:0];
			end
		end
	end

	assign done     = done_q;
	assign out_x    = res_q[0];
	assign out_y    = res_q[1];
	assign out_z    = res_q[2];
	assign remove   = remove_q;
	assign last_out = last_q;

	// Every result strobe belongs to a transaction accepted one latency earlier.
	a_done_has_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LATENCY))
		else $error("result strobe without a matching start");

	// A removed particle passes through unchanged (checked on x and z).
	a_remove_passes: assert property (@(posedge clk) disable iff (!arst_n)
		done && remove |-> (out_x == $past(pos_x, LATENCY)) && (out_z == $past(pos_z, LATENCY)))
		else $error("removed particle position altered");

	// Removal only happens in kill mode.
	a_remove_kill: assert property (@(posedge clk) disable iff (!arst_n)
		done && remove |-> !mode_q)
		else $error("remove flag raised in constrain mode");

endmodule

[rtl/sbkc_sqrt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbkc_sqrt
// Pipelined floor square root of a 66-bit value, one root bit per stage.
// ----------------------------------------------------------------------------
module sbkc_sqrt (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  sbkc_pkg::item_t     in_item,
	input  logic [65:0]         in_rad,
	output logic                out_valid,
	output sbkc_pkg::item_t     out_item,
	output logic [33:0]         out_root
);
	import sbkc_pkg::*;

	logic        vld_s  [SQ_STEPS];
	item_t       item_s [SQ_STEPS];
	logic [65:0] rad_s  [SQ_STEPS];
	logic [36:0] rem_s  [SQ_STEPS];
	logic [33:0] root_s [SQ_STEPS];

	for (genvar g = 0; g < SQ_STEPS; g++) begin : g_step
		logic        vld_in;
		item_t       item_in;
		logic [65:0] rad_in;
		logic [36:0] rem_in;
		logic [33:0] root_in;
		logic [1:0]  pair;
		logic [36:0] rem_sh;
		logic [36:0] trial;
		logic        ge;

		// The radicand is treated as 68 bits, so the first stage brings down
		// a leading zero pair and the radicand bits start at the second stage.
		if (g == 0) begin : g_first
			assign vld_in  = in_valid;
			assign item_in = in_item;
			assign rad_in  = in_rad;
			assign rem_in  = '0;
			assign root_in = '0;
			assign pair    = 2'b00;
		end else begin : g_next
			assign vld_in  = vld_s[g-1];
			assign item_in = item_s[g-1];
			assign rad_in  = rad_s[g-1];
			assign rem_in  = rem_s[g-1];
			assign root_in = root_s[g-1];
			assign pair    = rad_in[65:64];
		end

		// Bring down the next bit pair and try the trial subtrahend.
		assign rem_sh = {rem_in[34:0], pair};
		assign trial  = {1'b0, root_in, 2'b01};
		assign ge     = (rem_sh >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else begin
				vld_s[g] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			item_s[g] <= item_in;
			rem_s[g]  <= ge ? (rem_sh - trial) : rem_sh;
			root_s[g] <= {root_in[32:0], ge};
		end

		// The radicand is only needed by the stages that follow.
		if (g < SQ_STEPS - 1) begin : g_rad
			always_ff @(posedge clk) begin
				rad_s[g] <= (g == 0) ? rad_in : {rad_in[63:0], 2'b00};
			end
		end else begin : g_rad_last
			assign rad_s[g] = '0;
		end
	end

	assign out_valid = vld_s[SQ_STEPS-1];
	assign out_item  = item_s[SQ_STEPS-1];
	assign out_root  = root_s[SQ_STEPS-1];

endmodule

[rtl/sbkc_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbkc_div
// Three-lane scaling unit: a multiply stage forms |diff| * radius, then a
// restoring divider by the distance yields one quotient bit per stage.
// ----------------------------------------------------------------------------
module sbkc_div (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  sbkc_pkg::item_t        in_item,
	input  logic [33:0]            in_dist,
	input  logic [30:0]            radius,
	output logic                   out_valid,
	output sbkc_pkg::meta_t        out_meta,
	output logic [2:0][30:0]       out_quot
);
	import sbkc_pkg::*;

	// Multiply stage.
	logic             vld_m;
	meta_t            meta_m;
	logic [33:0]      dist_m;
	logic [2:0][62:0] prod_m;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_m <= 1'b0;
		end else begin
			vld_m <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		meta_m <= in_item.meta;
		dist_m <= (in_dist == '0) ? 34'd1 : in_dist;
		for (int k = 0; k < 3; k++) begin
			prod_m[k] <= 63'(in_item.mag[k] * radius);
		end
	end

	// Division stages; the quotient is known to stay below 2^31.
	logic             vld_s  [QBITS];
	meta_t            meta_s [QBITS];
	logic [33:0]      dist_s [QBITS];
	logic [2:0][62:0] prod_s [QBITS];
	logic [2:0][33:0] rem_s  [QBITS];
	logic [2:0][30:0] quot_s [QBITS];

	for (genvar g = 0; g < QBITS; g++) begin : g_step
		logic             vld_in;
		meta_t            meta_in;
		logic [33:0]      dist_in;
		logic [2:0][62:0] prod_in;
		logic [2:0][33:0] rem_in;
		logic [2:0][30:0] quot_in;
		logic [2:0][33:0] rem_nx;
		logic [2:0]       qbit;

		if (g == 0) begin : g_first
			assign vld_in  = vld_m;
			assign meta_in = meta_m;
			assign dist_in = dist_m;
			assign prod_in = prod_m;
			assign quot_in = '0;
			for (genvar k = 0; k < 3; k++) begin : g_init
				assign rem_in[k] = {2'b00, prod_m[k][62:31]};
			end
		end else begin : g_next
			assign vld_in  = vld_s[g-1];
			assign meta_in = meta_s[g-1];
			assign dist_in = dist_s[g-1];
			assign prod_in = prod_s[g-1];
			assign rem_in  = rem_s[g-1];
			assign quot_in = quot_s[g-1];
		end

		// Shift in the next dividend bit and subtract the divisor if it fits.
		always_comb begin
			logic [34:0] sh;
			for (int k = 0; k < 3; k++) begin
				sh = {rem_in[k], prod_in[k][QBITS-1-g]};
				qbit[k] = (sh >= {1'b0, dist_in});
				rem_nx[k] = qbit[k] ? 34'(sh - {1'b0, dist_in}) : sh[33:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else begin
				vld_s[g] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			meta_s[g] <= meta_in;
			dist_s[g] <= dist_in;
			rem_s[g]  <= rem_nx;
			for (int k = 0; k < 3; k++) begin
				quot_s[g][k] <= {quot_in[k][29:0], qbit[k]};
			end
		end

		// The dividend is only needed by the stages that follow.
		if (g < QBITS - 1) begin : g_prod
			always_ff @(posedge clk) begin
				prod_s[g] <= prod_in;
			end
		end else begin : g_prod_last
			assign prod_s[g] = '0;
		end
	end

	assign out_valid = vld_s[QBITS-1];
	assign out_meta  = meta_s[QBITS-1];
	assign out_quot  = quot_s[QBITS-1];

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sphere bounds kill-or-clamp testbench
// Drives particle positions through the block under several sphere settings,
// predicts results with an exact fixed-point sphere model (directed rows carry
// their own) and compares every result field against the oldest expected result.
// ----------------------------------------------------------------------------
module testbench;
	import sbkc_pkg::*;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_CENTER_X = 3'd0,
		REG_CENTER_Y = 3'd1,
		REG_CENTER_Z = 3'd2,
		REG_RADIUS   = 3'd3,
		REG_MODE     = 3'd4,
		REG_UNUSED   = 3'd7
	} reg_index_e;

	localparam logic MODE_KILL      = 1'b0;
	localparam logic MODE_CONSTRAIN = 1'b1;

	typedef struct {
		logic [31:0] x, y, z;
		logic        rm, last;
	} particle_result_t;

	typedef struct {
		logic [31:0]      x, y, z;
		logic             last;
		logic             known;
		particle_result_t res;
	} stim_row_t;

	logic clk, arst_n;
	logic start, busy;
	logic [31:0] pos_x, pos_y, pos_z;
	logic last_particle;
	logic cfg_valid, cfg_ready;
	logic [2:0] cfg_index;
	logic [31:0] cfg_data;
	logic done;
	logic [31:0] out_x, out_y, out_z;
	logic remove, last_out;

	sphere_bounds_kill_or_clamp uut (.*);

	// Predictor copy of the registers.
	logic signed [31:0] ctr [3];
	logic [30:0] rad;
	logic mode;

	particle_result_t pending_results[$];
	int errors = 0;
	int idle_pct = 18;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	// Floor square root of an unsigned value below 2^66.
	function automatic logic [33:0] floor_sqrt(logic [65:0] v);
		logic [67:0] rem;
		logic [35:0] root;
		logic [67:0] trial;
		rem = 0;
		root = 0;
		for (int i = 33; i >= 0; i--) begin
			rem = (rem << 2) | ((v >> (2 * i)) & 66'd3);
			trial = {root, 2'b01};
			if (rem >= trial) begin
				rem = rem - trial;
				root = {root[34:0], 1'b1};
			end else begin
				root = {root[34:0], 1'b0};
			end
		end
		return root[33:0];
	endfunction

	// Sphere test and, when constraining, projection onto the surface.
	function automatic particle_result_t sphere_predict(logic [31:0] px, logic [31:0] py,
			logic [31:0] pz, logic lst);
		particle_result_t r;
		logic signed [32:0] d [3];
		logic [32:0] m [3];
		logic [65:0] sumsq;
		logic [61:0] r2;
		logic [33:0] root_dist;
		logic [63:0] q;
		logic signed [65:0] o;
		logic [31:0] p [3];
		p[0] = px; p[1] = py; p[2] = pz;
		sumsq = 0;
		for (int k = 0; k < 3; k++) begin
			d[k] = $signed({p[k][31], p[k]}) - $signed({ctr[k][31], ctr[k]});
			m[k] = d[k][32] ? 33'(-d[k]) : 33'(d[k]);
			sumsq = sumsq + 66'(m[k]) * 66'(m[k]);
		end
		r2 = 62'(rad) * 62'(rad);
		r.x = px; r.y = py; r.z = pz;
		r.rm = 1'b0;
		r.last = lst;
		if (sumsq > 66'(r2)) begin
			if (mode == MODE_KILL) begin
				r.rm = 1'b1;
			end else begin
				root_dist = floor_sqrt(sumsq);
				if (root_dist == 0)
					root_dist = 1;
				for (int k = 0; k < 3; k++) begin
					q = (64'(m[k]) * 64'(rad)) / 64'(root_dist);
					o = $signed({2'b00, q});
					if (d[k][32])
						o = -o;
					o = o + $signed(ctr[k]);
					if (o > 66'sh7FFFFFFF)
						p[k] = 32'h7FFFFFFF;
					else if (o < -66'sh80000000)
						p[k] = 32'h80000000;
					else
						p[k] = o[31:0];
				end
				r.x = p[0]; r.y = p[1]; r.z = p[2];
			end
		end
		return r;
	endfunction

	// Configuration write transaction; predictor follows at acceptance.
	task automatic write_reg(reg_index_e idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_CENTER_X: ctr[0] = val;
			REG_CENTER_Y: ctr[1] = val;
			REG_CENTER_Z: ctr[2] = val;
			REG_RADIUS:   rad = val[30:0];
			REG_MODE:     mode = val[0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Wait for all results, then the pipeline latency, before reconfiguring.
	task automatic drain();
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// One particle transaction, with random idle cycles in front.
	task automatic send_particle(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
			logic lst, logic known, particle_result_t exp_res);
		particle_result_t r;
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		pos_x <= px;
		pos_y <= py;
		pos_z <= pz;
		last_particle <= lst;
		do @(posedge clk); while (busy);
		r = known ? exp_res : sphere_predict(px, py, pz, lst);
		pending_results.push_back(r);
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(5))
			0: return $urandom;
			1: return 32'h80000000 + $urandom_range(3);
			2: return 32'h7FFFFFFF - $urandom_range(3);
			default: return 32'($signed($urandom_range(16 << 16)) - (8 << 16));
		endcase
	endfunction

	// Result checker: a strobe with nothing pending is a failure.
	always @(posedge clk) begin
		particle_result_t e;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result x=%h y=%h z=%h", $time, out_x, out_y, out_z);
				errors++;
			end else begin
				e = pending_results.pop_front();
				if (out_x !== e.x || out_y !== e.y || out_z !== e.z
						|| remove !== e.rm || last_out !== e.last) begin
					$display("%0t: mismatch expected x=%h y=%h z=%h rm=%b last=%b",
						$time, e.x, e.y, e.z, e.rm, e.last);
					$display("%0t:          actual   x=%h y=%h z=%h rm=%b last=%b",
						$time, out_x, out_y, out_z, remove, last_out);
					errors++;
				end
			end
		end
	end

	stim_row_t directed[$];

	task automatic add_row(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic lst,
			logic known, logic rm);
		stim_row_t s;
		s.x = x; s.y = y; s.z = z; s.last = lst; s.known = known;
		s.res.x = x; s.res.y = y; s.res.z = z; s.res.rm = rm; s.res.last = lst;
		directed.push_back(s);
	endtask

	task automatic run_random(int n);
		particle_result_t none;
		for (int i = 0; i < n; i++)
			send_particle(rand_coord(), rand_coord(), rand_coord(), 1'($urandom), 1'b0, none);
		start <= 1'b0;
	endtask

	initial begin
		particle_result_t none;
		arst_n = 1'b0;
		start = 1'b0;
		pos_x = 0; pos_y = 0; pos_z = 0;
		last_particle = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_CENTER_X;
		cfg_data = 0;
		ctr[0] = 0; ctr[1] = 0; ctr[2] = 0;
		rad = 31'd196608;
		mode = MODE_KILL;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows at reset settings (kill mode, radius 3.0, center origin).
		add_row(32'h0, 32'h0, 32'h0, 1'b0, 1'b1, 1'b0);
		add_row(32'h00030000, 32'h0, 32'h0, 1'b1, 1'b1, 1'b0);
		add_row(32'h00030001, 32'h0, 32'h0, 1'b0, 1'b1, 1'b1);
		add_row(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b1, 1'b1, 1'b1);
		add_row(32'h80000000, 32'h80000000, 32'h80000000, 1'b0, 1'b1, 1'b1);
		add_row(32'hFFFF0000, 32'h00010000, 32'hFFFFFFFF, 1'b1, 1'b1, 1'b0);
		foreach (directed[i])
			send_particle(directed[i].x, directed[i].y, directed[i].z, directed[i].last,
				directed[i].known, directed[i].res);
		start <= 1'b0;
		drain();

		// Constrain mode with an extreme center and the largest radius.
		write_reg(REG_MODE, 32'd1);
		write_reg(REG_CENTER_X, 32'h7FFFFFFF);
		write_reg(REG_CENTER_Y, 32'h80000000);
		write_reg(REG_CENTER_Z, 32'h0);
		write_reg(REG_RADIUS, 32'h7FFFFFFF);
		write_reg(REG_UNUSED, 32'hFFFFFFFF);
		send_particle(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b1, 1'b0, none);
		send_particle(32'h7FFFFFFF, 32'h80000000, 32'h0, 1'b0, 1'b0, none);
		run_random(100);
		drain();

		// Constrain with a tiny and then a zero radius: outside points land at or near the center.
		write_reg(REG_CENTER_X, 32'h00010000);
		write_reg(REG_CENTER_Y, 32'hFFFE0000);
		write_reg(REG_CENTER_Z, 32'h00008000);
		write_reg(REG_RADIUS, 32'd655);
		send_particle(32'h00010000, 32'hFFFE0000, 32'h00008001, 1'b0, 1'b0, none);
		run_random(80);
		drain();
		write_reg(REG_RADIUS, 32'd0);
		send_particle(32'h00010000, 32'hFFFE0000, 32'h00008000, 1'b1, 1'b0, none);
		send_particle(32'h00010001, 32'hFFFE0000, 32'h00008000, 1'b0, 1'b0, none);
		run_random(60);
		drain();

		// Typical sphere, constrain then kill; a long stretch with no idling.
		write_reg(REG_CENTER_X, 32'h00020000);
		write_reg(REG_CENTER_Y, 32'hFFFD0000);
		write_reg(REG_CENTER_Z, 32'h00000000);
		write_reg(REG_RADIUS, 32'h00050000);
		run_random(150);
		idle_pct = 0;
		run_random(100);
		idle_pct = 18;
		drain();
		write_reg(REG_MODE, 32'd0);
		run_random(150);
		drain();

		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
